[rtl/core/bdpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int NOW_BITS          = 32;
   localparam int LIMIT_BITS        = 8;
   localparam int DELAY_BITS        = 16;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd5;
   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd1000;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2,
      EV_LONG    = 2'd3
   } event_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INTEGRATOR_LIMIT = 2'd0,
      CSR_LONG_PRESS_MS    = 2'd1,
      CSR_USE_INTEGRATOR   = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] integrator_limit;
      logic [DELAY_BITS-1:0] long_press_ms;
      logic                  use_integrator;
   } cfg_type;

endpackage

[rtl/core/bdpc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_if
// Valid/ready channels: button samples, classifier results and CSR writes.
// ----------------------------------------------------------------------------
interface bdpc_req_if;
   logic        valid;
   logic        ready;
   logic        raw_level;
   logic [31:0] now_ms;
   modport source (output valid, output raw_level, output now_ms, input ready);
   modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_code;
   logic       clean_level;
   modport source (output valid, output event_code, output clean_level, input ready);
   modport sink   (input valid, input event_code, input clean_level, output ready);
endinterface

interface bdpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/button_debounce_press_classifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top
// The result of a sample transfer is registered straight into the output register.
// Throughput: one sample per cycle; the output register is refilled in the
// cycle it is taken, so rsp stalls hold back req only while a result waits.
// Reset: synchronous, active high; the CSR registers return to their documented
// defaults and classifier state returns to released, not held.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top
   import bdpc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bdpc_req_if.sink   req_if,
   bdpc_rsp_if.source rsp_if,
   bdpc_csr_if.sink   csr_if
);

   cfg_type              cfg_ff;
   logic                 rsp_valid_ff;
   event_type            event_ff;
   logic                 level_ff;
   logic                 step;
   logic                 debounced;
   logic                 level;
   event_type            event_code;
   logic [TIME_BITS+NOW_BITS-1:0] now_wide;
   logic [TIME_BITS-1:0] now_t;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.integrator_limit <= LIMIT_RESET;
         cfg_ff.long_press_ms    <= DELAY_RESET;
         cfg_ff.use_integrator   <= 1'b1;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_INTEGRATOR_LIMIT: cfg_ff.integrator_limit <= csr_if.data[LIMIT_BITS-1:0];
            CSR_LONG_PRESS_MS:    cfg_ff.long_press_ms    <= csr_if.data;
            CSR_USE_INTEGRATOR:   cfg_ff.use_integrator   <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign step         = req_if.valid && req_if.ready;

   // zero-extend or truncate the timestamp to the time width
   assign now_wide = {{TIME_BITS{1'b0}}, req_if.now_ms};
   assign now_t    = now_wide[TIME_BITS-1:0];

   bdpc_integrator u_integrator (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .raw_level        (req_if.raw_level),
      .integrator_limit (cfg_ff.integrator_limit),
      .debounced_in     (debounced)
   );

   assign level = cfg_ff.use_integrator ? debounced : req_if.raw_level;

   bdpc_classifier #(
      .TIME_BITS (TIME_BITS)
   ) u_classifier (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .level         (level),
      .now_t         (now_t),
      .long_press_ms (cfg_ff.long_press_ms),
      .event_code    (event_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         event_ff <= event_code;
         level_ff <= level;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.event_code  = event_ff;
   assign rsp_if.clean_level = level_ff;

endmodule

[rtl/core/bdpc_integrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_integrator
// Saturating up/down integrator that debounces the raw pin level.
// ----------------------------------------------------------------------------
module bdpc_integrator
   import bdpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  raw_level,
   input  logic [LIMIT_BITS-1:0] integrator_limit,
   output logic                  debounced_in
);

   logic [LIMIT_BITS-1:0] count_ff, count_in;
   logic                  debounced_ff;
   logic [LIMIT_BITS-1:0] limit;
   logic [LIMIT_BITS-1:0] stepped;

   // a zero limit behaves as one
   assign limit = (integrator_limit == '0) ? LIMIT_BITS'(1) : integrator_limit;

   always_comb begin
      stepped = count_ff;
      if (!raw_level) begin
         if (count_ff != '0) stepped = count_ff - LIMIT_BITS'(1);
      end else if (count_ff < limit) begin
         stepped = count_ff + LIMIT_BITS'(1);
      end
      count_in     = stepped;
      debounced_in = debounced_ff;
      if (stepped == '0) begin
         debounced_in = 1'b0;
      end else if (stepped >= limit) begin
         // also clamps a count left above a lowered limit
         count_in     = limit;
         debounced_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= LIMIT_RESET;
         debounced_ff <= 1'b1;
      end else if (step) begin
         count_ff     <= count_in;
         debounced_ff <= debounced_in;
      end
   end

endmodule

[rtl/core/bdpc_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_classifier
// Press, release and long-press detection on the classified level.
// ----------------------------------------------------------------------------
module bdpc_classifier
   import bdpc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  level,
   input  logic [TIME_BITS-1:0]  now_t,
   input  logic [DELAY_BITS-1:0] long_press_ms,
   output event_type             event_code
);

   logic                 prev_ff;
   logic                 held_ff, held_in;
   logic                 long_ff, long_in;
   logic [TIME_BITS-1:0] press_time_ff, press_time_in;
   logic                 press, release_ev;
   logic [TIME_BITS-1:0] held_time;

   assign press      = !level && prev_ff && !held_ff;
   assign release_ev = !prev_ff && level && (held_ff || press);

   always_comb begin
      held_in       = held_ff || press;
      long_in       = long_ff;
      press_time_in = press ? now_t : press_time_ff;
      held_time     = now_t - press_time_in;
      event_code    = press ? EV_PRESS : EV_NONE;
      priority if (release_ev) begin
         if (!long_ff) event_code = EV_RELEASE;
         held_in       = 1'b0;
         long_in       = 1'b0;
         press_time_in = '0;
      end else if (held_in && !long_ff && held_time >= TIME_BITS'(long_press_ms)) begin
         // a zero delay lets this override the press report
         event_code    = EV_LONG;
         long_in       = 1'b1;
         press_time_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= 1'b1;
         held_ff       <= 1'b0;
         long_ff       <= 1'b0;
         press_time_ff <= '0;
      end else if (step) begin
         prev_ff       <= level;
         held_ff       <= held_in;
         long_ff       <= long_in;
         press_time_ff <= press_time_in;
      end
   end

endmodule

[sim/button_debounce_press_classifier_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top_tb
// Self-checking bench for the debounce and press classifier. A queue of
// button samples and register writes feeds a valid/ready driver. Each sample
// transfer runs through a local model of the integrator and the classifier.
// The monitor checks every result transfer, field by field, against the
// oldest prediction. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top_tb;
   import bdpc_pkg::*;

   localparam int TB_TIME_BITS   = TIME_BITS_DEFAULT;
   localparam int RANDOM_SAMPLES = 1300;

   typedef struct packed {
      logic                raw_level;
      logic [NOW_BITS-1:0] now_ms;
   } button_sample_type;

   typedef struct packed {
      event_type event_code;
      logic      clean_level;
   } press_result_type;

   typedef enum logic [1:0] {
      STEP_SAMPLE,
      STEP_CSR_WRITE,
      STEP_WAIT_IDLE
   } step_kind_type;

   typedef struct {
      step_kind_type              kind;
      int unsigned                gap;
      button_sample_type          sample;
      csr_index_type              index;
      logic [CSR_DATA_BITS-1:0]   data;
   } stim_step_type;

   logic clock;
   logic reset;

   bdpc_req_if req_if ();
   bdpc_rsp_if rsp_if ();
   bdpc_csr_if csr_if ();

   button_debounce_press_classifier_top #(
      .TIME_BITS (TB_TIME_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Pending stimulus and the predictions still waiting for a result
   stim_step_type    stim_q[$];
   press_result_type expected_q[$];

   // Classifier model state
   cfg_type                 model_cfg;
   logic [LIMIT_BITS-1:0]   integ_count;
   logic                    debounced_level;
   logic                    last_level;
   logic                    held;
   logic                    long_done;
   logic [TB_TIME_BITS-1:0] press_stamp;

   // Driver state
   button_sample_type        cur_sample;
   csr_index_type            cur_index;
   logic [CSR_DATA_BITS-1:0] cur_data;
   int unsigned              gap_left;
   bit                       req_fire;
   bit                       csr_fire;
   bit                       block_idle;
   bit                       next_req;
   bit                       next_csr;

   // Monitor state
   int unsigned stall_left;
   int unsigned stall_mode;
   int unsigned mon_cycles;
   press_result_type want;

   int unsigned sent_count = 0;
   int unsigned recv_count = 0;
   int unsigned csr_writes = 0;
   int unsigned error_count = 0;
   int unsigned events_seen[4] = '{0, 0, 0, 0};

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------
   function automatic void reset_model();
      model_cfg.integrator_limit = LIMIT_RESET;
      model_cfg.long_press_ms    = DELAY_RESET;
      model_cfg.use_integrator   = 1'b1;
      integ_count     = LIMIT_RESET;
      debounced_level = 1'b1;
      last_level      = 1'b1;
      held            = 1'b0;
      long_done       = 1'b0;
      press_stamp     = '0;
   endfunction

   function automatic void write_register(input csr_index_type idx,
                                          input logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_INTEGRATOR_LIMIT: model_cfg.integrator_limit = value[LIMIT_BITS-1:0];
         CSR_LONG_PRESS_MS:    model_cfg.long_press_ms    = value[DELAY_BITS-1:0];
         CSR_USE_INTEGRATOR:   model_cfg.use_integrator   = value[0];
         default: ;
      endcase
   endfunction

   function automatic press_result_type classify_sample(input button_sample_type s);
      logic [LIMIT_BITS-1:0]   lim;
      logic                    level;
      event_type               ev;
      logic [TB_TIME_BITS-1:0] now_t;
      logic [TB_TIME_BITS-1:0] held_for;
      press_result_type        r;
      lim = (model_cfg.integrator_limit == '0) ? LIMIT_BITS'(1) : model_cfg.integrator_limit;
      if (!s.raw_level) begin
         if (integ_count != '0)
            integ_count = integ_count - 1'b1;
      end else if (integ_count < lim) begin
         integ_count = integ_count + 1'b1;
      end
      // count may sit above a freshly lowered limit; clamp releases the level
      if (integ_count == '0) begin
         debounced_level = 1'b0;
      end else if (integ_count >= lim) begin
         integ_count     = lim;
         debounced_level = 1'b1;
      end
      level = model_cfg.use_integrator ? debounced_level : s.raw_level;
      now_t = s.now_ms;
      ev    = EV_NONE;
      if (!level && last_level && !held) begin
         held        = 1'b1;
         press_stamp = now_t;
         ev          = EV_PRESS;
      end
      if (!last_level && level && held) begin
         if (!long_done)
            ev = EV_RELEASE;
         long_done   = 1'b0;
         press_stamp = '0;
         held        = 1'b0;
      end else begin
         held_for = now_t - press_stamp;
         // zero delay lets long press overwrite a press in the same sample
         if (held && !long_done && held_for >= model_cfg.long_press_ms) begin
            ev          = EV_LONG;
            long_done   = 1'b1;
            press_stamp = '0;
         end
      end
      last_level    = level;
      r.event_code  = ev;
      r.clean_level = level;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic int unsigned draw_gap(input bit burst);
      int unsigned r;
      if (burst)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned draw_stall(input int unsigned mode);
      int unsigned r;
      r = $urandom_range(0, 99);
      case (mode)
         0: return 0;
         1: return (r < 50) ? 0 : $urandom_range(1, 3);
         default: begin
            if (r < 80)
               return 0;
            else if (r < 95)
               return $urandom_range(1, 4);
            else
               return $urandom_range(15, 60);
         end
      endcase
   endfunction

   task automatic add_sample(input logic raw, input logic [NOW_BITS-1:0] t,
                             input int unsigned gap);
      stim_step_type st;
      st.kind             = STEP_SAMPLE;
      st.gap              = gap;
      st.sample.raw_level = raw;
      st.sample.now_ms    = t;
      st.index            = CSR_UNUSED;
      st.data             = '0;
      stim_q.push_back(st);
   endtask

   task automatic add_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      stim_step_type st;
      st.kind   = STEP_CSR_WRITE;
      st.gap    = 0;
      st.sample = '0;
      st.index  = idx;
      st.data   = value;
      stim_q.push_back(st);
   endtask

   task automatic add_wait_idle();
      stim_step_type st;
      st.kind   = STEP_WAIT_IDLE;
      st.gap    = 0;
      st.sample = '0;
      st.index  = CSR_UNUSED;
      st.data   = '0;
      stim_q.push_back(st);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int unsigned lim_eff;
      int unsigned dt_max;
      int unsigned phase_len;
      int unsigned phase_count;
      int unsigned total;
      int unsigned n;
      int unsigned r;
      logic [LIMIT_BITS-1:0] lim;
      logic [DELAY_BITS-1:0] delay;
      logic                  use_int;
      logic [NOW_BITS-1:0]   t;
      bit                    burst;

      // limit lowered under the reset count, then press and long press together
      add_csr(CSR_INTEGRATOR_LIMIT, 16'd2);
      add_csr(CSR_LONG_PRESS_MS, 16'd0);
      add_sample(1'b0, 32'd0, 0);
      add_sample(1'b0, 32'd1, 0);
      add_sample(1'b0, 32'd2, 0);
      add_sample(1'b1, 32'd3, 0);
      add_sample(1'b1, 32'd4, 1);
      // bypass mode, longest delay across the timestamp wrap
      add_csr(CSR_LONG_PRESS_MS, 16'hFFFF);
      add_csr(CSR_USE_INTEGRATOR, 16'd0);
      add_sample(1'b0, 32'hFFFF_FFF0, 0);
      add_sample(1'b0, 32'h0000_FFEE, 0);
      add_sample(1'b0, 32'h0000_FFEF, 0);
      add_sample(1'b1, 32'h0001_0000, 2);
      add_sample(1'b0, 32'hFFFF_FFFF, 0);
      add_sample(1'b1, 32'h0000_0000, 0);
      // zero limit behaves as one; junk in the upper data bits
      add_csr(CSR_INTEGRATOR_LIMIT, 16'hFF00);
      add_csr(CSR_USE_INTEGRATOR, 16'hFFFF);
      add_csr(CSR_LONG_PRESS_MS, 16'd1);
      add_sample(1'b0, 32'd10, 0);
      add_sample(1'b1, 32'd11, 0);
      add_sample(1'b0, 32'd12, 0);
      add_sample(1'b0, 32'd13, 3);
      add_sample(1'b1, 32'd14, 0);
      add_sample(1'b1, 32'd15, 0);
      add_csr(CSR_INTEGRATOR_LIMIT, 16'd255);
      add_csr(CSR_UNUSED, 16'hA5A5);
      add_sample(1'b1, 32'd100, 0);
      add_sample(1'b0, 32'h5555_AAAA, 0);
      add_sample(1'b1, 32'hAAAA_5555, 0);
      add_wait_idle();

      total = 0;
      while (total < RANDOM_SAMPLES) begin
         r = $urandom_range(0, 9);
         case (r)
            0: lim = 8'd0;
            1: lim = 8'd1;
            2: lim = 8'd255;
            3: lim = LIMIT_BITS'($urandom_range(2, 255));
            default: lim = LIMIT_BITS'($urandom_range(1, 8));
         endcase
         r = $urandom_range(0, 9);
         case (r)
            0: delay = 16'd0;
            1: delay = 16'd1;
            2: delay = 16'hFFFF;
            3: delay = DELAY_BITS'($urandom);
            default: delay = DELAY_BITS'($urandom_range(1, 300));
         endcase
         use_int = ($urandom_range(0, 3) != 0);
         add_csr(CSR_INTEGRATOR_LIMIT, {8'($urandom), lim});
         add_csr(CSR_LONG_PRESS_MS, delay);
         add_csr(CSR_USE_INTEGRATOR, {15'($urandom), use_int});
         if ($urandom_range(0, 4) == 0)
            add_csr(CSR_UNUSED, CSR_DATA_BITS'($urandom));

         lim_eff     = (lim == 0) ? 1 : lim;
         dt_max      = delay / 8 + 1;
         t           = ($urandom_range(0, 3) == 0) ?
                       32'hFFFF_FFFF - $urandom_range(0, 4 * dt_max) : $urandom;
         burst       = ($urandom_range(0, 3) == 0);
         phase_len   = $urandom_range(60, 140);
         phase_count = 0;
         while (phase_count < phase_len) begin
            if ($urandom_range(0, 9) < 2) begin
               add_sample(1'($urandom_range(0, 1)), $urandom, draw_gap(burst));
               phase_count++;
            end else begin
               // bounce, hold pressed, bounce, hold released
               for (int seg = 0; seg < 4; seg++) begin
                  n = (seg == 0 || seg == 2) ? $urandom_range(0, 4) :
                      $urandom_range(1, lim_eff + 12);
                  for (int k = 0; k < n; k++) begin
                     t = t + $urandom_range(0, dt_max);
                     add_sample((seg == 1) ? 1'b0 : (seg == 3) ? 1'b1 :
                                1'($urandom_range(0, 1)), t, draw_gap(burst));
                  end
                  phase_count += n;
               end
            end
            if ($urandom_range(0, 49) == 0)
               add_wait_idle();
         end
         total += phase_count;
      end
   end

   // ------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_if.valid <= 1'b0;
         gap_left = 0;
         reset_model();
      end else begin
         req_fire = req_if.valid && req_if.ready;
         csr_fire = csr_if.valid && csr_if.ready;
         if (req_fire) begin
            expected_q.push_back(classify_sample(cur_sample));
            sent_count <= sent_count + 1;
         end
         if (csr_fire) begin
            write_register(cur_index, cur_data);
            csr_writes++;
         end
         // both counters hold their pre-edge values here, so this is conservative
         block_idle = !req_if.valid && !csr_if.valid && sent_count == recv_count;
         if (!(req_if.valid && !req_fire) && !(csr_if.valid && !csr_fire)) begin
            next_req = 1'b0;
            next_csr = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (stim_q.size() != 0) begin
               case (stim_q[0].kind)
                  STEP_SAMPLE: begin
                     cur_sample = stim_q[0].sample;
                     gap_left   = stim_q[0].gap;
                     next_req   = 1'b1;
                     req_if.raw_level <= stim_q[0].sample.raw_level;
                     req_if.now_ms    <= stim_q[0].sample.now_ms;
                     void'(stim_q.pop_front());
                  end
                  STEP_CSR_WRITE: begin
                     if (block_idle) begin
                        cur_index = stim_q[0].index;
                        cur_data  = stim_q[0].data;
                        next_csr  = 1'b1;
                        csr_if.index <= stim_q[0].index;
                        csr_if.data  <= stim_q[0].data;
                        void'(stim_q.pop_front());
                     end
                  end
                  STEP_WAIT_IDLE: begin
                     if (block_idle)
                        void'(stim_q.pop_front());
                  end
               endcase
            end
            req_if.valid <= next_req;
            csr_if.valid <= next_csr;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         stall_mode = 0;
         mon_cycles = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            recv_count <= recv_count + 1;
            events_seen[rsp_if.event_code]++;
            if (expected_q.size() == 0) begin
               $error("result transfer with no sample pending: event_code %0d clean_level %0d",
                      rsp_if.event_code, rsp_if.clean_level);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_if.event_code !== want.event_code) begin
                  $error("event_code: expected %0d, got %0d", want.event_code,
                         rsp_if.event_code);
                  error_count++;
               end
               if (rsp_if.clean_level !== want.clean_level) begin
                  $error("clean_level: expected %0d, got %0d", want.clean_level,
                         rsp_if.clean_level);
                  error_count++;
               end
            end
         end
         mon_cycles++;
         if (mon_cycles % 256 == 0)
            stall_mode = $urandom_range(0, 2);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = draw_stall(stall_mode);
         end
      end
   end

   // ------------------------------------------------------------------
   // Reset, end of run
   // ------------------------------------------------------------------
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.raw_level = 1'b1;
      req_if.now_ms    = '0;
      csr_if.valid     = 1'b0;
      csr_if.index     = CSR_UNUSED;
      csr_if.data      = '0;
      rsp_if.ready     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do
         @(negedge clock);
      while (stim_q.size() != 0 || req_if.valid || csr_if.valid || sent_count != recv_count);
      repeat (5) @(negedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d predicted results never arrived", expected_q.size());
         error_count++;
      end
      $display("Run covered %0d button samples and %0d register writes.",
               sent_count, csr_writes);
      $display("Events seen: %0d none, %0d press, %0d release, %0d long press.",
               events_seen[EV_NONE], events_seen[EV_PRESS], events_seen[EV_RELEASE],
               events_seen[EV_LONG]);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[sim.f]
rtl/core/bdpc_pkg.sv
rtl/core/bdpc_if.sv
rtl/core/bdpc_integrator.sv
rtl/core/bdpc_classifier.sv
rtl/core/button_debounce_press_classifier_top.sv
sim/button_debounce_press_classifier_top_tb.sv
